@@ rtl/lz4d_pkg.sv @@
// Shared types, constants and helpers for the LZ4 block decompressor.
`default_nettype none

package lz4d_pkg;

	localparam int HIST_DEPTH = 65536;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int OUT_LANES  = 8;
	localparam int LANE_IW    = $clog2(OUT_LANES);
	localparam int CNT_W      = 24;
	localparam int MIN_MATCH  = 4;

	localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [3:0]       NIB_EXT  = 4'hF;
	localparam logic [7:0]       BYTE_EXT = 8'hFF;

	// action codes
	typedef enum logic [1:0] {
		ACT_IDLE  = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_START = 2'd2,
		ACT_SPARE = 2'd3
	} action_t;

	// block status codes
	typedef enum logic [2:0] {
		ST_RUN    = 3'd0,
		ST_DONE   = 3'd1,
		ST_TRUNC  = 3'd2,
		ST_BADOFF = 3'd3,
		ST_CAP    = 3'd4
	} status_t;

	// parse phase, one-hot
	typedef enum logic [7:0] {
		PH_TOKEN    = 8'b0000_0001,
		PH_LITEXT   = 8'b0000_0010,
		PH_LIT      = 8'b0000_0100,
		PH_OFFLO    = 8'b0000_1000,
		PH_OFFHI    = 8'b0001_0000,
		PH_MATCHEXT = 8'b0010_0000,
		PH_COPY     = 8'b0100_0000,
		PH_HALT     = 8'b1000_0000
	} phase_t;

	// copy engine state, one-hot
	typedef enum logic [1:0] {
		E_IDLE = 2'b01,
		E_COPY = 2'b10
	} eng_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic                      byte_taken;
		logic [3:0]                out_count;
		logic [OUT_LANES*8-1:0]    out_bytes;
		logic [2:0]                status;
		logic [CNT_W-1:0]          decoded_total;
	} out_word_t;

	// saturating length extension
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [7:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-7){1'b0}}, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	// length would overrun capacity (or has saturated)
	function automatic logic over_cap(input logic [CNT_W-1:0] len,
			input logic [CNT_W-1:0] prod, input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = {1'b0, prod} + {1'b0, len};
		return (len == CNT_MAX) || (s > {1'b0, cap});
	endfunction

endpackage

`default_nettype wire

@@ rtl/lz4d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lz4d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/lz4_block_decompressor_top.sv @@
// LZ4 block decompressor: one result word per input word, history in a 64 KiB RAM.
// A match-copy word writes up to 8 copied bytes into its result word before that result is registered;
// the copy is limited by the single read port of the history RAM and runs one byte per cycle.
// Throughput: one compressed byte per cycle, held while a copy runs or the output stalls.
// Reset: arst_n clears all control state; history RAM contents are undefined until written.
`default_nettype none

module lz4_block_decompressor_top import lz4d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_word_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_word_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	// state registers
	logic [HIST_AW-1:0] wp_q;
	logic [CNT_W-1:0]   prod_q, lit_q, mat_q, cap_q;
	logic [15:0]        off_q;
	logic [3:0]         nib_q;
	phase_t             phase_q;
	status_t            stat_q;

	// copy engine
	eng_t               eng_q;
	logic [LANE_IW-1:0] k_q;
	logic [3:0]         n_q;
	logic [HIST_AW-1:0] rp_q;
	logic [7:0]         buf_q [OUT_LANES];

	logic               oval_q;
	out_word_t          out_q;

	// RAM ports
	logic               ram_we;
	logic [HIST_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]         ram_wdata, ram_rdata;

	lz4d_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic accept, is_copy_start, copy_last;
	assign in_ready  = (eng_q == E_IDLE) && (!oval_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = oval_q;
	assign out_data  = out_q;

	// copy byte: from this word's output when the offset is short, else history
	logic       from_buf;
	logic [7:0] cp_val;
	logic [3:0] n_start;
	assign from_buf = off_q <= {{(16-LANE_IW){1'b0}}, k_q};
	assign cp_val   = from_buf ? buf_q[k_q - off_q[LANE_IW-1:0]] : ram_rdata;
	assign copy_last = (eng_q == E_COPY) && (({1'b0, k_q} + 4'd1) == n_q);
	assign n_start  = (mat_q >= CNT_W'(OUT_LANES)) ? 4'(OUT_LANES) : mat_q[3:0];
	assign is_copy_start = accept && (in_data.action != ACT_START) && (phase_q == PH_COPY);

	assign ram_raddr = (eng_q == E_IDLE) ? (wp_q - off_q) : rp_q;

	// parse a compressed byte
	logic       lit_we;
	logic [CNT_W-1:0] n_lit, n_mat, len_c;
	logic [15:0] n_off;
	logic [3:0]  n_nib;
	phase_t      n_phase;
	status_t     n_stat;
	logic        take;

	always_comb begin
		n_lit   = lit_q;
		n_mat   = mat_q;
		n_off   = off_q;
		n_nib   = nib_q;
		n_phase = phase_q;
		n_stat  = stat_q;
		lit_we  = 1'b0;
		len_c   = '0;
		take    = (in_data.action == ACT_BYTE) && (phase_q != PH_HALT)
			&& (phase_q != PH_COPY);
		if (take) begin
			unique case (phase_q)
				PH_TOKEN: begin
					n_nib = in_data.in_byte[3:0];
					if (in_data.in_byte[7:4] == NIB_EXT) begin
						n_lit = CNT_W'(15);
						if (in_data.in_last) begin
							n_stat = ST_TRUNC; n_phase = PH_HALT;
						end else begin
							n_phase = PH_LITEXT;
						end
					end else begin
						len_c = {{(CNT_W-4){1'b0}}, in_data.in_byte[7:4]};
						n_lit = len_c;
						if (over_cap(len_c, prod_q, cap_q)) begin
							n_stat = ST_CAP; n_phase = PH_HALT;
						end else if (in_data.in_last) begin
							n_stat = (len_c == '0) ? ST_DONE : ST_TRUNC; n_phase = PH_HALT;
						end else begin
							n_phase = (len_c != '0) ? PH_LIT : PH_OFFLO;
						end
					end
				end
				PH_LITEXT: begin
					len_c = sat_add(lit_q, in_data.in_byte);
					n_lit = len_c;
					if (in_data.in_byte == BYTE_EXT) begin
						if (in_data.in_last) begin
							n_stat = ST_TRUNC; n_phase = PH_HALT;
						end
					end else if (over_cap(len_c, prod_q, cap_q)) begin
						n_stat = ST_CAP; n_phase = PH_HALT;
					end else if (in_data.in_last) begin
						n_stat = (len_c == '0) ? ST_DONE : ST_TRUNC; n_phase = PH_HALT;
					end else begin
						n_phase = (len_c != '0) ? PH_LIT : PH_OFFLO;
					end
				end
				PH_LIT: begin
					lit_we = 1'b1;
					n_lit  = lit_q - CNT_W'(1);
					if (n_lit == '0) begin
						if (in_data.in_last) begin
							n_stat = ST_DONE; n_phase = PH_HALT;
						end else begin
							n_phase = PH_OFFLO;
						end
					end else if (in_data.in_last) begin
						n_stat = ST_TRUNC; n_phase = PH_HALT;
					end
				end
				PH_OFFLO: begin
					n_off = {8'd0, in_data.in_byte};
					if (in_data.in_last) begin
						n_stat = ST_TRUNC; n_phase = PH_HALT;
					end else begin
						n_phase = PH_OFFHI;
					end
				end
				PH_OFFHI: begin
					n_off = {in_data.in_byte, off_q[7:0]};
					if (n_off == '0 || {{(CNT_W-16){1'b0}}, n_off} > prod_q) begin
						n_stat = ST_BADOFF; n_phase = PH_HALT;
					end else if (in_data.in_last) begin
						n_stat = ST_TRUNC; n_phase = PH_HALT;
					end else if (nib_q == NIB_EXT) begin
						n_mat   = CNT_W'(15 + MIN_MATCH);
						n_phase = PH_MATCHEXT;
					end else begin
						n_mat = {{(CNT_W-4){1'b0}}, nib_q} + CNT_W'(MIN_MATCH);
						if (over_cap(n_mat, prod_q, cap_q)) begin
							n_stat = ST_CAP; n_phase = PH_HALT;
						end else begin
							n_phase = PH_COPY;
						end
					end
				end
				PH_MATCHEXT: begin
					n_mat = sat_add(mat_q, in_data.in_byte);
					if (in_data.in_last) begin
						n_stat = ST_TRUNC; n_phase = PH_HALT;
					end else if (in_data.in_byte != BYTE_EXT) begin
						if (over_cap(n_mat, prod_q, cap_q)) begin
							n_stat = ST_CAP; n_phase = PH_HALT;
						end else begin
							n_phase = PH_COPY;
						end
					end
				end
				default: begin
					n_phase = phase_q;
				end
			endcase
		end
	end

	// history write: literal on accept, copy byte during the copy loop
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = in_data.in_byte;
		if (eng_q == E_COPY) begin
			ram_we    = 1'b1;
			ram_wdata = cp_val;
		end else if (accept && in_data.action != ACT_START && lit_we) begin
			ram_we = 1'b1;
		end
	end

	// final copy word, current byte merged in
	logic [OUT_LANES*8-1:0] cp_bytes;
	always_comb begin
		for (int i = 0; i < OUT_LANES; i++) begin
			cp_bytes[i*8 +: 8] = (LANE_IW'(i) == k_q) ? cp_val : buf_q[i];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_MAX;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// decoder state, copy engine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			prod_q  <= '0;
			lit_q   <= '0;
			mat_q   <= '0;
			off_q   <= '0;
			nib_q   <= '0;
			phase_q <= PH_TOKEN;
			stat_q  <= ST_RUN;
			eng_q   <= E_IDLE;
			k_q     <= '0;
			n_q     <= '0;
			rp_q    <= '0;
			oval_q  <= 1'b0;
			out_q   <= '0;
			for (int i = 0; i < OUT_LANES; i++) begin
				buf_q[i] <= '0;
			end
		end else begin
			if (oval_q && out_ready) begin
				oval_q <= 1'b0;
			end
			if (eng_q == E_COPY) begin
				buf_q[k_q] <= cp_val;
				wp_q <= wp_q + HIST_AW'(1);
				rp_q <= rp_q + HIST_AW'(1);
				k_q  <= k_q + LANE_IW'(1);
				if (copy_last) begin
					eng_q  <= E_IDLE;
					prod_q <= prod_q + {{(CNT_W-4){1'b0}}, n_q};
					mat_q  <= mat_q - {{(CNT_W-4){1'b0}}, n_q};
					if (mat_q == {{(CNT_W-4){1'b0}}, n_q}) begin
						phase_q <= PH_TOKEN;
					end
					oval_q <= 1'b1;
					out_q.byte_taken    <= 1'b0;
					out_q.out_count     <= n_q;
					out_q.out_bytes     <= cp_bytes;
					out_q.status        <= stat_q;
					out_q.decoded_total <= prod_q + {{(CNT_W-4){1'b0}}, n_q};
				end
			end else if (accept) begin
				if (in_data.action == ACT_START) begin
					wp_q    <= '0;
					prod_q  <= '0;
					lit_q   <= '0;
					mat_q   <= '0;
					off_q   <= '0;
					nib_q   <= '0;
					phase_q <= PH_TOKEN;
					stat_q  <= ST_RUN;
					oval_q  <= 1'b1;
					out_q   <= '0;
				end else if (is_copy_start) begin
					eng_q <= E_COPY;
					k_q   <= '0;
					n_q   <= n_start;
					rp_q  <= wp_q - off_q + HIST_AW'(1);
					for (int i = 0; i < OUT_LANES; i++) begin
						buf_q[i] <= '0;
					end
				end else begin
					lit_q   <= n_lit;
					mat_q   <= n_mat;
					off_q   <= n_off;
					nib_q   <= n_nib;
					phase_q <= n_phase;
					stat_q  <= n_stat;
					if (lit_we) begin
						wp_q   <= wp_q + HIST_AW'(1);
						prod_q <= prod_q + CNT_W'(1);
					end
					oval_q <= 1'b1;
					out_q.byte_taken <= take;
					out_q.out_count  <= lit_we ? 4'd1 : 4'd0;
					out_q.out_bytes  <= lit_we ?
						{{(OUT_LANES*8-8){1'b0}}, in_data.in_byte} : '0;
					out_q.status        <= n_stat;
					out_q.decoded_total <= lit_we ? prod_q + CNT_W'(1) : prod_q;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the LZ4 block decompressor: directed and random LZ4 blocks, scored per word.
`default_nettype none

module tb;
	import lz4d_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_word_t in_data;
	out_word_t out_data;
	logic [CNT_W-1:0] cfg_data;

	lz4_block_decompressor_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// parse phases of the predictor
	typedef enum int {P_TOKEN, P_LITEXT, P_LIT, P_OFFLO, P_OFFHI, P_MATCHEXT, P_COPY, P_HALT}
		parse_t;

	// predictor state
	logic [7:0]       hist_mem [0:HIST_DEPTH-1];
	logic [15:0]      wr_pos;
	logic [CNT_W-1:0] produced, lit_left, match_left, capacity;
	logic [15:0]      offset;
	logic [3:0]       m_nib;
	logic [2:0]       blk_status;
	parse_t           parse;

	in_word_t  pending_words[$];
	out_word_t expected_words[$];
	int        errors, n_in, n_out, n_cfg;
	bit        calm, hold_sender;

	// word on in_data was taken at the last rising edge
	logic in_taken;

	function automatic bit too_long(logic [CNT_W-1:0] len);
		return len == CNT_MAX || ({1'b0, produced} + {1'b0, len}) > {1'b0, capacity};
	endfunction

	function automatic logic [CNT_W-1:0] len_add(logic [CNT_W-1:0] a, logic [7:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + b;
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	task automatic stop_with(logic [2:0] st);
		blk_status = st;
		parse = P_HALT;
	endtask

	task automatic emit(logic [7:0] b);
		hist_mem[wr_pos] = b;
		wr_pos++;
		produced++;
	endtask

	task automatic lit_len_done(bit last);
		if (too_long(lit_left)) stop_with(ST_CAP);
		else if (last) stop_with(lit_left == 0 ? ST_DONE : ST_TRUNC);
		else parse = (lit_left != 0) ? P_LIT : P_OFFLO;
	endtask

	// decode one input word and queue the word it should produce
	task automatic decode_word(in_word_t w);
		out_word_t r;
		logic [7:0] b, v;
		bit last;
		r = '0;
		b = w.in_byte;
		last = w.in_last;
		if (w.action == ACT_START) begin
			wr_pos = 0; produced = 0; parse = P_TOKEN; lit_left = 0; match_left = 0;
			offset = 0; m_nib = 0; blk_status = ST_RUN;
		end else if (parse == P_COPY) begin
			while (r.out_count < OUT_LANES && match_left != 0) begin
				v = hist_mem[wr_pos - offset];
				emit(v);
				r.out_bytes[8*r.out_count +: 8] = v;
				r.out_count++;
				match_left--;
			end
			if (match_left == 0) parse = P_TOKEN;
		end else if (w.action == ACT_BYTE && parse != P_HALT) begin
			r.byte_taken = 1'b1;
			case (parse)
			P_TOKEN: begin
				m_nib = b[3:0];
				if (b[7:4] == NIB_EXT) begin
					lit_left = 15;
					if (last) stop_with(ST_TRUNC);
					else parse = P_LITEXT;
				end else begin
					lit_left = CNT_W'(b[7:4]);
					lit_len_done(last);
				end
			end
			P_LITEXT: begin
				lit_left = len_add(lit_left, b);
				if (b == BYTE_EXT) begin
					if (last) stop_with(ST_TRUNC);
				end else lit_len_done(last);
			end
			P_LIT: begin
				emit(b);
				r.out_bytes[7:0] = b;
				r.out_count = 1;
				lit_left--;
				if (lit_left == 0) begin
					if (last) stop_with(ST_DONE);
					else parse = P_OFFLO;
				end else if (last) stop_with(ST_TRUNC);
			end
			P_OFFLO: begin
				offset = {8'h00, b};
				if (last) stop_with(ST_TRUNC);
				else parse = P_OFFHI;
			end
			P_OFFHI: begin
				offset[15:8] = b;
				if (offset == 0 || offset > produced) stop_with(ST_BADOFF);
				else if (last) stop_with(ST_TRUNC);
				else if (m_nib == NIB_EXT) begin
					match_left = CNT_W'(15 + MIN_MATCH);
					parse = P_MATCHEXT;
				end else begin
					match_left = CNT_W'(m_nib) + CNT_W'(MIN_MATCH);
					if (too_long(match_left)) stop_with(ST_CAP);
					else parse = P_COPY;
				end
			end
			default: begin
				match_left = len_add(match_left, b);
				if (last) stop_with(ST_TRUNC);
				else if (b != BYTE_EXT) begin
					if (too_long(match_left)) stop_with(ST_CAP);
					else parse = P_COPY;
				end
			end
			endcase
		end
		r.status = blk_status;
		r.decoded_total = produced;
		expected_words.push_back(r);
	endtask

	// stimulus builders
	function automatic in_word_t mk(action_t a, logic [7:0] b, bit l);
		in_word_t w;
		w.action = a; w.in_byte = b; w.in_last = l;
		return w;
	endfunction

	task automatic put(action_t a, logic [7:0] b, bit l);
		pending_words.push_back(mk(a, b, l));
	endtask

	// the extension bytes of a length field for len (called only when len >= 15)
	task automatic put_ext(int len);
		int rest;
		rest = len - 15;
		while (rest >= 255) begin
			put(ACT_BYTE, 8'hFF, 0);
			rest -= 255;
		end
		put(ACT_BYTE, rest[7:0], 0);
	endtask

	// a well-formed block, with matches that only reach back into this block
	task automatic put_block(int n_seq, int max_lit);
		int made, lit, mlen, off;
		made = 0;
		put(ACT_START, 8'h00, 0);
		for (int s = 0; s < n_seq; s++) begin
			lit = $urandom_range(max_lit, (made == 0) ? 1 : 0);
			mlen = $urandom_range(30, 4);
			if ($urandom_range(9, 0) == 0) mlen = $urandom_range(300, 4);
			put(ACT_BYTE, {(lit >= 15) ? 4'hF : lit[3:0],
				(mlen - 4 >= 15) ? 4'hF : 4'(mlen - 4)}, 0);
			if (lit >= 15) put_ext(lit);
			for (int i = 0; i < lit; i++) begin
				if ($urandom_range(19, 0) == 0) put(ACT_IDLE, 8'($urandom), 0);
				put(ACT_BYTE, 8'($urandom), 0);
			end
			made += lit;
			off = $urandom_range(made, 1);
			if ($urandom_range(3, 0) == 0) off = $urandom_range((made < 8) ? made : 8, 1);
			put(ACT_BYTE, off[7:0], 0);
			put(ACT_BYTE, off[15:8], 0);
			if (mlen - 4 >= 15) put_ext(mlen - 4);
			made += mlen;
		end
		lit = $urandom_range(6, 0);
		put(ACT_BYTE, {lit[3:0], 4'($urandom)}, lit == 0);
		for (int i = 0; i < lit; i++) put(ACT_BYTE, 8'($urandom), i == lit - 1);
	endtask

	// a block with random corruption or early end
	task automatic put_noise(int n);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'h30, 0);
		for (int i = 0; i < 3; i++) put(ACT_BYTE, 8'($urandom), 0);
		for (int i = 0; i < n; i++)
			pending_words.push_back(mk(action_t'($urandom_range(3, 0)), 8'($urandom),
				$urandom_range(7, 0) == 0));
	endtask

	// send what is queued, then pause the sender until every result is back
	task automatic drain();
		while (pending_words.size() != 0)
			@(posedge clk);
		hold_sender = 1'b1;
		while (in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
	endtask

	task automatic set_capacity(logic [CNT_W-1:0] c);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		capacity = c;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// handshake seen at the last rising edge
	always @(posedge clk) in_taken <= arst_n && in_valid && in_ready;

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_words.size() != 0 && !hold_sender && (calm || $urandom_range(99, 0) >= 10))
			begin
				in_data <= pending_words.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= calm || $urandom_range(99, 0) >= 10;
	end

	// predictor fed at each accepted input word
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			decode_word(in_data);
			n_in++;
		end
	end

	// result checker
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			n_out++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (out_data.byte_taken !== e.byte_taken) begin
					$display("%0t: byte_taken exp %0d got %0d", $time, e.byte_taken,
						out_data.byte_taken);
					errors++;
				end
				if (out_data.out_count !== e.out_count) begin
					$display("%0t: out_count exp %0d got %0d", $time, e.out_count,
						out_data.out_count);
					errors++;
				end
				if (out_data.out_bytes !== e.out_bytes) begin
					$display("%0t: out_bytes exp %h got %h", $time, e.out_bytes,
						out_data.out_bytes);
					errors++;
				end
				if (out_data.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
					errors++;
				end
				if (out_data.decoded_total !== e.decoded_total) begin
					$display("%0t: decoded_total exp %0d got %0d", $time, e.decoded_total,
						out_data.decoded_total);
					errors++;
				end
			end
		end
	end

	// main sequence
	initial begin
		in_valid = 0; in_data = '0; out_ready = 0; cfg_valid = 0; cfg_data = '0;
		errors = 0; n_in = 0; n_out = 0; n_cfg = 0; calm = 0; hold_sender = 0;
		wr_pos = 0; produced = 0; lit_left = 0; match_left = 0; offset = 0; m_nib = 0;
		blk_status = ST_RUN; parse = P_TOKEN; capacity = CNT_MAX;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty sequence end, literal-only, overlap copy, bad offsets, truncation, capacity limits
		put(ACT_BYTE, 8'h00, 1);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'h1F, 0); put(ACT_BYTE, 8'hA5, 0);
		put(ACT_BYTE, 8'h01, 0); put(ACT_BYTE, 8'h00, 0); put(ACT_BYTE, 8'h00, 0);
		put(ACT_SPARE, 8'h00, 0);
		put(ACT_BYTE, 8'h10, 0); put(ACT_BYTE, 8'hFF, 1);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'h10, 0); put(ACT_BYTE, 8'h00, 0);
		put(ACT_BYTE, 8'h00, 0); put(ACT_BYTE, 8'h00, 0);
		put(ACT_BYTE, 8'h00, 0);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'h10, 0); put(ACT_BYTE, 8'h11, 0);
		put(ACT_BYTE, 8'h02, 0); put(ACT_BYTE, 8'h00, 0);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'hF0, 0); put(ACT_BYTE, 8'hFF, 1);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'h20, 0); put(ACT_BYTE, 8'h5A, 1);
		set_capacity(0);
		put(ACT_START, 8'h00, 0);
		put(ACT_BYTE, 8'h10, 0);
		set_capacity(3);
		put(ACT_START, 8'h00, 0); put(ACT_BYTE, 8'h30, 0);
		put(ACT_BYTE, 8'h01, 0); put(ACT_BYTE, 8'h02, 0); put(ACT_BYTE, 8'h03, 0);
		put(ACT_BYTE, 8'h01, 0); put(ACT_BYTE, 8'h00, 0);
		set_capacity(CNT_MAX);
		drain();

		// random blocks across a few capacities
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			1: set_capacity(CNT_W'($urandom_range(200, 20)));
			2: set_capacity(CNT_MAX - 1);
			3: set_capacity(CNT_MAX);
			default: ;
			endcase
			calm = (ph == 2);
			while (n_in + pending_words.size() < 400 * (ph + 1)) begin
				if ($urandom_range(4, 0) == 0) put_noise($urandom_range(30, 5));
				else put_block($urandom_range(4, 1), $urandom_range(20, 1));
			end
		end
		calm = 0;
		drain();
		$display("Covered %0d input words, %0d results, %0d capacity writes.", n_in, n_out, n_cfg);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
